@@ rtl/imh_pkg.sv @@
`timescale 1ns / 1ps

package imh_pkg;

    localparam int KEY_W    = 64;
    localparam int POS_W    = 10;
    localparam int HDL_W    = 16;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    // At most this many move beats are reported for one input.
    localparam int MAX_MOVES = 11;
    localparam int MCNT_W    = 4;

    localparam logic KIND_UPSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  new_value;
        logic [HDL_W-1:0]  entry_handle;
    } imh_in_t;

    typedef struct packed {
        logic [HDL_W-1:0]    moved_handle;
        logic [POS_W-1:0]    moved_position;
        logic                has_move;
        logic [CNT_W-1:0]    entry_count;
        logic [KEY_W-1:0]    min_value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } imh_out_t;

    typedef struct packed {
        logic     valid;
        imh_out_t data;
    } imh_emit_t;

    function automatic imh_out_t make_move(input logic [HDL_W-1:0] hdl,
                                           input logic [POS_W-1:0] pos);
        imh_out_t o;
        o = '0;
        o.moved_handle   = hdl;
        o.moved_position = pos;
        o.has_move       = 1'b1;
        return o;
    endfunction

    function automatic imh_out_t make_final(input logic [CNT_W-1:0]    cnt,
                                            input logic [KEY_W-1:0]    min_key,
                                            input logic [STATUS_W-1:0] st);
        imh_out_t o;
        o = '0;
        o.entry_count = cnt;
        o.min_value   = min_key;
        o.status      = st;
        o.last        = 1'b1;
        return o;
    endfunction

endpackage

@@ rtl/indexed_min_heap.sv @@
`timescale 1ns / 1ps
// Channel   Ports                        Beat contents
// input     s_valid, s_ready, s_data     one upsert or delete command
// output    m_valid, m_ready, m_data     one move beat, or the closing beat with last set
//
// A rejected command, or the delete of the last entry, only reads the root for the closing beat.
// Any other command sifts the entry up one parent read at a time, or down
// by reading the left and then the right child, and then places the entry;
// every step waits on the one registered read of the heap memory.
// Reset leaves the heap empty; the memory itself is never cleared.
// A stalled output holds the sequencer on its next beat, and s_ready
// stays low until the closing beat of the current command is handed over.

module indexed_min_heap
    import imh_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  imh_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output imh_out_t m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int RW = KEY_W + HANDLE_BITS;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    imh_emit_t     emit;
    logic          out_free;
    logic          m_valid_reg, m_valid_next;
    imh_out_t      m_data_reg;

    imh_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    imh_seq #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: a new beat may load as the held one is taken.
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = emit.valid ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_data_reg <= emit.data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/imh_ram.sv @@
`timescale 1ns / 1ps

module imh_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/imh_seq.sv @@
`timescale 1ns / 1ps

module imh_seq
    import imh_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 16,
    localparam int AW  = $clog2(CAPACITY),
    localparam int CW  = $clog2(CAPACITY + 1),
    localparam int RW  = KEY_W + HANDLE_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  imh_in_t       s_data,
    input  logic          out_free,
    output imh_emit_t     emit,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [RW-1:0] ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [RW-1:0] ram_rdata
);

    localparam int XW  = (CW > POS_W) ? CW : POS_W;
    localparam int XCW = AW + 2;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DEL_RD = 12'b0000_0000_0010,
        S_DEL_MV = 12'b0000_0000_0100,
        S_UP_RD  = 12'b0000_0000_1000,
        S_UP_CMP = 12'b0000_0001_0000,
        S_DN_RDL = 12'b0000_0010_0000,
        S_DN_L   = 12'b0000_0100_0000,
        S_DN_R   = 12'b0000_1000_0000,
        S_DN_MV  = 12'b0001_0000_0000,
        S_PLACE  = 12'b0010_0000_0000,
        S_FIN_RD = 12'b0100_0000_0000,
        S_FIN_OUT= 12'b1000_0000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [MCNT_W-1:0]       mcnt_reg, mcnt_next;
    logic                    first_reg, first_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [HANDLE_BITS-1:0]  hdl_reg, hdl_next;
    logic [KEY_W-1:0]        best_key_reg, best_key_next;
    logic [HANDLE_BITS-1:0]  best_hdl_reg, best_hdl_next;
    logic [AW-1:0]           best_pos_reg, best_pos_next;

    logic [KEY_W-1:0]        rd_key;
    logic [HANDLE_BITS-1:0]  rd_hdl;
    logic [KEY_W-1:0]        cmp_a, cmp_b;
    logic                    lt;
    logic [XW-1:0]           in_pos_x, cnt_x;
    logic [AW-1:0]           parent;
    logic [XCW-1:0]          lch, rch, cnt_c;
    logic                    move_ok;

    assign rd_key   = ram_rdata[HANDLE_BITS +: KEY_W];
    assign rd_hdl   = ram_rdata[HANDLE_BITS-1:0];
    assign in_pos_x = XW'(s_data.position);
    assign cnt_x    = XW'(count_reg);
    assign parent   = (pos_reg - 1'b1) >> 1;
    assign lch      = (XCW'(pos_reg) << 1) + 1'b1;
    assign rch      = lch + 1'b1;
    assign cnt_c    = XCW'(count_reg);
    assign move_ok  = (mcnt_reg < MCNT_W'(MAX_MOVES));
    assign s_ready  = (state_reg == S_IDLE);

    // The one key comparator, steered by the sequencer state.
    always_comb begin
        case (state_reg)
            S_UP_CMP: begin
                cmp_a = key_reg;
                cmp_b = rd_key;
            end
            S_DN_R: begin
                cmp_a = rd_key;
                cmp_b = best_key_reg;
            end
            default: begin
                cmp_a = rd_key;
                cmp_b = key_reg;
            end
        endcase
    end
    assign lt = (cmp_a < cmp_b);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        mcnt_next     = mcnt_reg;
        first_next    = first_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        hdl_next      = hdl_reg;
        best_key_next = best_key_reg;
        best_hdl_next = best_hdl_reg;
        best_pos_next = best_pos_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = {key_reg, hdl_reg};
        ram_re        = 1'b0;
        ram_raddr     = pos_reg;
        emit          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next = ST_OK;
                    mcnt_next   = '0;
                    first_next  = 1'b1;
                    key_next    = s_data.new_value;
                    hdl_next    = HANDLE_BITS'(s_data.entry_handle);
                    if (s_data.kind == KIND_UPSERT) begin
                        if (in_pos_x < cnt_x) begin
                            pos_next   = AW'(s_data.position);
                            state_next = (AW'(s_data.position) == '0) ? S_DN_RDL : S_UP_RD;
                        end else if (count_reg == CW'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_FIN_RD;
                        end else begin
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            state_next = (count_reg == '0) ? S_DN_RDL : S_UP_RD;
                        end
                    end else begin
                        if (in_pos_x >= cnt_x) begin
                            status_next = ST_RANGE;
                            state_next  = S_FIN_RD;
                        end else begin
                            pos_next   = AW'(s_data.position);
                            count_next = count_reg - 1'b1;
                            state_next = (in_pos_x == cnt_x - 1'b1) ? S_FIN_RD : S_DEL_RD;
                        end
                    end
                end
            end

            // The count already excludes the last slot, so it addresses it.
            S_DEL_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(count_reg);
                state_next = S_DEL_MV;
            end

            S_DEL_MV: begin
                if (out_free) begin
                    key_next   = rd_key;
                    hdl_next   = rd_hdl;
                    emit.valid = move_ok;
                    emit.data  = make_move(HDL_W'(rd_hdl), POS_W'(pos_reg));
                    mcnt_next  = move_ok ? mcnt_reg + 1'b1 : mcnt_reg;
                    state_next = (pos_reg == '0) ? S_DN_RDL : S_UP_RD;
                end
            end

            S_UP_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = parent;
                state_next = S_UP_CMP;
            end

            // On the first level a key that does not rise is sifted down instead.
            S_UP_CMP: begin
                if (lt) begin
                    if (out_free) begin
                        ram_we     = 1'b1;
                        ram_wdata  = ram_rdata;
                        emit.valid = move_ok;
                        emit.data  = make_move(HDL_W'(rd_hdl), POS_W'(pos_reg));
                        mcnt_next  = move_ok ? mcnt_reg + 1'b1 : mcnt_reg;
                        first_next = 1'b0;
                        pos_next   = parent;
                        state_next = (parent == '0) ? S_PLACE : S_UP_RD;
                    end
                end else begin
                    state_next = first_reg ? S_DN_RDL : S_PLACE;
                end
            end

            S_DN_RDL: begin
                if (lch < cnt_c) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(lch);
                    state_next = S_DN_L;
                end else begin
                    state_next = S_PLACE;
                end
            end

            S_DN_L: begin
                if (lt) begin
                    best_key_next = rd_key;
                    best_hdl_next = rd_hdl;
                    best_pos_next = AW'(lch);
                end else begin
                    best_key_next = key_reg;
                    best_hdl_next = hdl_reg;
                    best_pos_next = pos_reg;
                end
                if (rch < cnt_c) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(rch);
                    state_next = S_DN_R;
                end else begin
                    state_next = S_DN_MV;
                end
            end

            S_DN_R: begin
                if (lt) begin
                    best_key_next = rd_key;
                    best_hdl_next = rd_hdl;
                    best_pos_next = AW'(rch);
                end
                state_next = S_DN_MV;
            end

            S_DN_MV: begin
                if (best_pos_reg == pos_reg) begin
                    state_next = S_PLACE;
                end else if (out_free) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {best_key_reg, best_hdl_reg};
                    emit.valid = move_ok;
                    emit.data  = make_move(HDL_W'(best_hdl_reg), POS_W'(pos_reg));
                    mcnt_next  = move_ok ? mcnt_reg + 1'b1 : mcnt_reg;
                    pos_next   = best_pos_reg;
                    state_next = S_DN_RDL;
                end
            end

            S_PLACE: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    emit.valid = move_ok;
                    emit.data  = make_move(HDL_W'(hdl_reg), POS_W'(pos_reg));
                    mcnt_next  = move_ok ? mcnt_reg + 1'b1 : mcnt_reg;
                    state_next = S_FIN_RD;
                end
            end

            S_FIN_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_FIN_OUT;
            end

            S_FIN_OUT: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.data  = make_final(CNT_W'(count_reg),
                                            (count_reg != '0) ? rd_key : '0, status_reg);
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
            mcnt_reg   <= '0;
            first_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            mcnt_reg   <= mcnt_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        hdl_reg      <= hdl_next;
        best_key_reg <= best_key_next;
        best_hdl_reg <= best_hdl_next;
        best_pos_reg <= best_pos_next;
    end

endmodule

@@ rtl/imh_checker.sv @@
`timescale 1ns / 1ps

module imh_checker
    import imh_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input imh_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output beat dropped before it was taken");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while a command is in progress");

    a_last_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> !m_data.has_move)
        else $error("closing beat flagged as a move");

    a_move_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.has_move && m_data.status == ST_OK
                                    && m_data.entry_count == '0)
        else $error("move beat carries summary fields");

    a_empty_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last && m_data.entry_count == '0 |-> m_data.min_value == '0)
        else $error("empty heap reports a nonzero minimum");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
